>>> hw/rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the subscriber table
// Field widths, opcodes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package stl_pkg;

  // default table geometry
  localparam int SLOTS_DEF        = 8;
  localparam int IDS_PER_SLOT_DEF = 8;

  // item field widths
  localparam int OP_W    = 2;
  localparam int MAC_W   = 48;
  localparam int TICK_W  = 32;
  localparam int COUNT_W = 8;
  localparam int ID_W    = 32;

  // result field widths
  localparam int SLOT_OUT_W  = 3;
  localparam int ALIVE_OUT_W = 4;

  // stream widths
  localparam int S_DATA_W = 120;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 16;

  localparam logic [TICK_W-1:0] LIVENESS_RESET = 32'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_ANNOUNCE = 2'd0,
    OP_ID       = 2'd1,
    OP_COUNT    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // outcome of a table walk
  typedef struct packed {
    logic found;     // address matched a used entry
    logic free_got;  // at least one unused slot
  } scan_flags_t;

endpackage

>>> hw/rtl/subscriber_table_lru_top.sv
// ----------------------------------------------------------------------------
// subscriber_table_lru_top: subscriber table with oldest-stamp eviction
// Address-keyed table of subscribers and their message ids.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_*: s_tuser carries the opcode (announce, id
//   element, count query), s_tdata the address, tick, id count and id.
//   Every word yields exactly one result word on m_* (m_tdata only). Write
//   liveness_ticks through cfg_we / cfg_data only while idle; not enforced.
// Sequence:
//   Announce and count query walk all SLOTS entries of the entry memory,
//   one read per cycle on its single read port: each address is issued,
//   its registered read data is checked in stl_scan, and after the last
//   check the block moves to ST_FINISH. Id elements and unused opcodes
//   go straight to ST_FINISH, which registers the result into m_tdata once
//   the output register is free. One word is in work at a time.
// Reset:
//   rst (synchronous) empties the table, clears the current slot and fill
//   position and loads liveness_ticks with 1000. s_tready is low during rst.
// Stall:
//   The result sits in an output register; a new word is taken while it
//   waits, and the block holds in its last step until m_tready frees it.
// ----------------------------------------------------------------------------
module subscriber_table_lru_top #(
  parameter int SLOTS        = stl_pkg::SLOTS_DEF,
  parameter int IDS_PER_SLOT = stl_pkg::IDS_PER_SLOT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [stl_pkg::TICK_W-1:0]    cfg_data,    // liveness_ticks
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // mac[47:0], now_tick[79:48], id_count[87:80], sub_id[119:88]
  input  logic [stl_pkg::S_DATA_W-1:0]  s_tdata,
  // op[1:0]
  input  logic [stl_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // slot[2:0], new_entry[3], evicted[4], truncated[5], alive_count[9:6], zero
  output logic [stl_pkg::M_DATA_W-1:0]  m_tdata
);

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int TOT_W   = $clog2(IDS_PER_SLOT + 1);
  localparam int ALIVE_W = $clog2(SLOTS + 1);
  localparam int IDA_W   = $clog2(SLOTS * IDS_PER_SLOT);
  localparam int ENT_W   = stl_pkg::MAC_W + stl_pkg::TICK_W + 1 + TOT_W;
  localparam int CNT_W   = stl_pkg::COUNT_W;

  stl_pkg::state_t state, state_next;

  // latched word
  stl_pkg::op_t                op;
  logic [stl_pkg::MAC_W-1:0]   mac;
  logic [stl_pkg::TICK_W-1:0]  now_tick;
  logic [CNT_W-1:0]            id_count;
  logic [stl_pkg::ID_W-1:0]    sub_id;

  logic [stl_pkg::TICK_W-1:0]  liveness_ticks;
  logic [SLOTS-1:0]            used;
  logic [SLOT_W-1:0]           cur_slot;
  logic [TOT_W-1:0]            fill;
  logic [TOT_W-1:0]            cur_total;   // id total of the current slot

  // walk control
  logic [SLOT_W:0]             issue_cnt;
  logic                        chk;
  logic [SLOT_W-1:0]           chk_idx;
  logic                        chk_last;

  logic                        in_acc;
  logic                        out_free;
  logic                        issue;
  logic                        scan_clear;
  logic                        finish;

  logic [ENT_W-1:0]            rd_data;
  logic [ENT_W-1:0]            wr_data;
  logic                        ent_we;
  logic                        id_we;
  logic [IDA_W-1:0]            id_addr;

  stl_pkg::scan_flags_t        flags;
  logic [SLOT_W-1:0]           hit_idx;
  logic [SLOT_W-1:0]           free_idx;
  logic [SLOT_W-1:0]           old_idx;
  logic [ALIVE_W-1:0]          alive;

  // write-back decisions
  logic [SLOT_W-1:0]           ann_idx;
  logic [TOT_W-1:0]            ann_total;
  logic                        ann_trunc;
  logic                        id_ok;
  logic [SLOT_W-1:0]           res_idx;
  logic [SLOT_W+2:0]           res_idx_wide;
  logic [ALIVE_W+3:0]          alive_wide;
  logic [stl_pkg::M_DATA_W-1:0] res_data;

  assign s_tready = (state == stl_pkg::ST_IDLE) && !rst;
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign issue    = (state == stl_pkg::ST_SCAN) && (issue_cnt < (SLOT_W+1)'(SLOTS));
  assign finish   = (state == stl_pkg::ST_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    scan_clear = 1'b0;
    unique case (state)
      stl_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (stl_pkg::op_t'(s_tuser) == stl_pkg::OP_ANNOUNCE ||
              stl_pkg::op_t'(s_tuser) == stl_pkg::OP_COUNT) begin
            state_next = stl_pkg::ST_SCAN;
            scan_clear = 1'b1;
          end else begin
            state_next = stl_pkg::ST_FINISH;
          end
        end
      end
      stl_pkg::ST_SCAN: begin
        if (chk && chk_last) begin
          state_next = stl_pkg::ST_FINISH;
        end
      end
      stl_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = stl_pkg::ST_IDLE;
        end
      end
      default: state_next = stl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op       <= stl_pkg::op_t'(s_tuser);
      mac      <= s_tdata[47:0];
      now_tick <= s_tdata[79:48];
      id_count <= s_tdata[87:80];
      sub_id   <= s_tdata[119:88];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      liveness_ticks <= stl_pkg::LIVENESS_RESET;
    end else if (cfg_we) begin
      liveness_ticks <= cfg_data;
    end
  end

  // walk: address issued in one cycle, checked in the next
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      chk       <= 1'b0;
    end else begin
      if (scan_clear) begin
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + (SLOT_W+1)'(1);
      end
      chk <= issue;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx  <= issue_cnt[SLOT_W-1:0];
    chk_last <= (issue_cnt == (SLOT_W+1)'(SLOTS - 1));
  end

  stl_entry_mem #(
    .DEPTH  (SLOTS),
    .DATA_W (ENT_W)
  ) u_entry_mem (
    .clk     (clk),
    .we      (ent_we),
    .wr_addr (ann_idx),
    .wr_data (wr_data),
    .rd_addr (issue_cnt[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  stl_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .clear          (scan_clear),
    .chk            (chk),
    .chk_idx        (chk_idx),
    .chk_used       (used[chk_idx]),
    .ent_addr       (rd_data[ENT_W-1 -: stl_pkg::MAC_W]),
    .ent_seen       (rd_data[ENT_W-stl_pkg::MAC_W-1 -: stl_pkg::TICK_W]),
    .mac            (mac),
    .now_tick       (now_tick),
    .liveness_ticks (liveness_ticks),
    .flags          (flags),
    .hit_idx        (hit_idx),
    .free_idx       (free_idx),
    .old_idx        (old_idx),
    .alive          (alive)
  );

  stl_id_mem #(
    .DEPTH (SLOTS * IDS_PER_SLOT)
  ) u_id_mem (
    .clk     (clk),
    .we      (id_we),
    .wr_addr (id_addr),
    .wr_data (sub_id)
  );

  // slot choice: match, else lowest free, else oldest stamp
  always_comb begin
    priority if (flags.found) begin
      ann_idx = hit_idx;
    end else if (flags.free_got) begin
      ann_idx = free_idx;
    end else begin
      ann_idx = old_idx;
    end
  end

  always_comb begin
    ann_trunc = id_count > CNT_W'(IDS_PER_SLOT);
    if (id_count == '0) begin
      ann_total = '0;
    end else if (ann_trunc) begin
      ann_total = TOT_W'(IDS_PER_SLOT);
    end else begin
      ann_total = id_count[TOT_W-1:0];
    end
  end

  assign wr_data = {mac, now_tick, (id_count == '0), ann_total};
  assign ent_we  = finish && (op == stl_pkg::OP_ANNOUNCE);
  assign id_ok   = fill < cur_total;
  assign id_we   = finish && (op == stl_pkg::OP_ID) && id_ok;
  assign id_addr = IDA_W'(cur_slot) * IDA_W'(IDS_PER_SLOT) + IDA_W'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      cur_slot  <= '0;
      fill      <= '0;
      cur_total <= '0;
    end else if (ent_we) begin
      used[ann_idx] <= 1'b1;
      cur_slot      <= ann_idx;
      fill          <= '0;
      cur_total     <= ann_total;
    end else if (id_we) begin
      fill <= fill + TOT_W'(1);
    end
  end

  assign res_idx      = (op == stl_pkg::OP_ANNOUNCE) ? ann_idx : cur_slot;
  assign res_idx_wide = {3'b000, res_idx};
  assign alive_wide   = {4'b0000, alive};

  always_comb begin
    res_data = '0;
    unique case (op)
      stl_pkg::OP_ANNOUNCE: begin
        res_data[2:0] = res_idx_wide[2:0];
        res_data[3]   = !flags.found;
        res_data[4]   = !flags.found && !flags.free_got;
        res_data[5]   = ann_trunc;
      end
      stl_pkg::OP_ID: begin
        res_data[2:0] = res_idx_wide[2:0];
        res_data[5]   = !id_ok;
      end
      stl_pkg::OP_COUNT: begin
        res_data[9:6] = alive_wide[3:0];
      end
      default: res_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= res_data;
    end
  end

endmodule

>>> hw/rtl/stl_entry_mem.sv
// ----------------------------------------------------------------------------
// stl_entry_mem: per-slot entry storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stl_entry_mem #(
  parameter int DEPTH  = stl_pkg::SLOTS_DEF,
  parameter int DATA_W = 88
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // the walk's reads and the write-back never overlap: they happen in separate states
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/stl_id_mem.sv
// ----------------------------------------------------------------------------
// stl_id_mem: subscribed id storage
// SLOTS x IDS_PER_SLOT words, flat addressed as slot * IDS_PER_SLOT + position.
// ----------------------------------------------------------------------------
module stl_id_mem #(
  parameter int DEPTH = stl_pkg::SLOTS_DEF * stl_pkg::IDS_PER_SLOT_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [stl_pkg::ID_W-1:0]   wr_data
);

  logic [stl_pkg::ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/stl_scan.sv
// ----------------------------------------------------------------------------
// stl_scan: table walk accumulator
// Takes one entry per cycle and tracks first match, lowest free slot,
// oldest stamp and the live-entry count.
// ----------------------------------------------------------------------------
module stl_scan #(
  parameter int SLOTS = stl_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clear,
  input  logic                            chk,
  input  logic [$clog2(SLOTS)-1:0]        chk_idx,
  input  logic                            chk_used,
  input  logic [stl_pkg::MAC_W-1:0]       ent_addr,
  input  logic [stl_pkg::TICK_W-1:0]      ent_seen,
  input  logic [stl_pkg::MAC_W-1:0]       mac,
  input  logic [stl_pkg::TICK_W-1:0]      now_tick,
  input  logic [stl_pkg::TICK_W-1:0]      liveness_ticks,
  output stl_pkg::scan_flags_t            flags,
  output logic [$clog2(SLOTS)-1:0]        hit_idx,
  output logic [$clog2(SLOTS)-1:0]        free_idx,
  output logic [$clog2(SLOTS)-1:0]        old_idx,
  output logic [$clog2(SLOTS+1)-1:0]      alive
);

  localparam int ALIVE_W = $clog2(SLOTS + 1);

  logic [stl_pkg::TICK_W-1:0] old_seen;
  logic [stl_pkg::TICK_W-1:0] age;
  logic                       is_hit;
  logic                       is_live;
  logic                       is_older;

  assign age      = now_tick - ent_seen;
  assign is_hit   = chk_used && (ent_addr == mac);
  assign is_live  = chk_used && (age < liveness_ticks);
  // strict compare keeps the lowest index on equal stamps
  assign is_older = (chk_idx == '0) || (ent_seen < old_seen);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags <= '0;
      alive <= '0;
    end else if (chk) begin
      if (is_hit && !flags.found) begin
        flags.found <= 1'b1;
      end
      if (!chk_used && !flags.free_got) begin
        flags.free_got <= 1'b1;
      end
      if (is_live) begin
        alive <= alive + ALIVE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk) begin
      if (is_hit && !flags.found) begin
        hit_idx <= chk_idx;
      end
      if (!chk_used && !flags.free_got) begin
        free_idx <= chk_idx;
      end
      if (is_older) begin
        old_idx  <= chk_idx;
        old_seen <= ent_seen;
      end
    end
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for subscriber_table_lru_top
// Drives announce, id element, count query and unused words with bursty
// valid and a stalling receiver, keeps its own copy of the subscriber table
// and checks every result word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import stl_pkg::*;

  localparam int                N_SLOTS    = SLOTS_DEF;
  localparam int                N_IDS      = IDS_PER_SLOT_DEF;
  localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
  localparam int                POOL_N     = 12;  // more addresses than slots
  localparam int                IDLE_LIMIT = 2000;
  localparam int                MAX_PRINTS = 32;

  typedef struct packed {
    logic [5:0]             pad;
    logic [ALIVE_OUT_W-1:0] alive;
    logic                   trunc;
    logic                   evict;
    logic                   fresh;
    logic [SLOT_OUT_W-1:0]  slot;
  } result_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [TICK_W-1:0]    cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata   = '0;
  logic [S_USER_W-1:0]  s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;

  subscriber_table_lru_top uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // mac, now_tick, id_count, sub_id
    .s_tuser  (s_tuser),   // op
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // slot, new_entry, evicted, truncated, alive_count
  );

  // shadow of the subscriber table
  logic              tbl_valid [N_SLOTS];
  logic [MAC_W-1:0]  tbl_mac   [N_SLOTS];
  logic [TICK_W-1:0] tbl_seen  [N_SLOTS];
  logic              tbl_wild  [N_SLOTS];
  int                tbl_total [N_SLOTS];
  logic [ID_W-1:0]   tbl_ids   [N_SLOTS][N_IDS];
  int                cur_slot;
  int                fill_pos;
  logic [TICK_W-1:0] live_limit;

  result_t           pending_results [$];

  int err_count   = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int rx_mode     = 0;
  int rx_cnt      = 0;
  int stall_left  = 0;
  int n_announce  = 0;
  int n_idword    = 0;
  int n_query     = 0;
  int n_other     = 0;
  int n_evict     = 0;
  int n_settings  = 0;

  logic [MAC_W-1:0]  mac_pool [POOL_N];
  logic [TICK_W-1:0] tick_now;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Update the shadow table with one accepted word and queue its result.
  task automatic advance_table(input logic [OP_W-1:0] op, input logic [MAC_W-1:0] mac,
                               input logic [TICK_W-1:0] now, input logic [COUNT_W-1:0] cnt,
                               input logic [ID_W-1:0] id);
    result_t           res;
    int                idx;
    logic              found;
    logic              got;
    logic [TICK_W-1:0] age;
    res   = '0;
    idx   = 0;
    found = 1'b0;
    got   = 1'b0;
    case (op)
      OP_ANNOUNCE: begin
        for (int i = 0; i < N_SLOTS; i++)
          if (!found && tbl_valid[i] && tbl_mac[i] == mac) begin
            idx   = i;
            found = 1'b1;
          end
        if (!found) begin
          for (int i = 0; i < N_SLOTS; i++)
            if (!got && !tbl_valid[i]) begin
              idx = i;
              got = 1'b1;
            end
          if (!got) begin
            // oldest raw stamp, lowest index on a tie
            idx = 0;
            for (int i = 1; i < N_SLOTS; i++)
              if (tbl_seen[i] < tbl_seen[idx]) idx = i;
            res.evict = 1'b1;
            n_evict++;
          end
          res.fresh      = 1'b1;
          tbl_wild[idx]  = 1'b0;
          tbl_total[idx] = 0;
          for (int k = 0; k < N_IDS; k++) tbl_ids[idx][k] = '0;
          tbl_mac[idx]   = mac;
          tbl_valid[idx] = 1'b1;
        end
        tbl_seen[idx] = now;
        if (cnt == 0) begin
          tbl_wild[idx]  = 1'b1;
          tbl_total[idx] = 0;
        end else begin
          tbl_wild[idx] = 1'b0;
          if (cnt > N_IDS) begin
            res.trunc      = 1'b1;
            tbl_total[idx] = N_IDS;
          end else begin
            tbl_total[idx] = cnt;
          end
        end
        cur_slot = idx;
        fill_pos = 0;
        res.slot = idx[SLOT_OUT_W-1:0];
      end
      OP_ID: begin
        res.slot  = cur_slot[SLOT_OUT_W-1:0];
        res.trunc = 1'b1;
        if (tbl_valid[cur_slot] && fill_pos < tbl_total[cur_slot]) begin
          tbl_ids[cur_slot][fill_pos] = id;
          fill_pos  = fill_pos + 1;
          res.trunc = 1'b0;
        end
      end
      OP_COUNT: begin
        for (int i = 0; i < N_SLOTS; i++) begin
          age = now - tbl_seen[i];
          if (tbl_valid[i] && age < live_limit) res.alive = res.alive + 1'b1;
        end
      end
      default: ;
    endcase
    pending_results.push_back(res);
  endtask

  // One word on the input stream; valid comes in bursts with random gaps.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [MAC_W-1:0] mac,
                           input logic [TICK_W-1:0] now, input logic [COUNT_W-1:0] cnt,
                           input logic [ID_W-1:0] id);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {id, cnt, now, mac};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    advance_table(op, mac, now, cnt, id);
    case (op)
      OP_ANNOUNCE: n_announce++;
      OP_ID:       n_idword++;
      OP_COUNT:    n_query++;
      default:     n_other++;
    endcase
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_liveness(input logic [TICK_W-1:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    live_limit  = value;
    n_settings++;
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MAC_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 85) return COUNT_W'($urandom_range(1, N_IDS));
    return COUNT_W'($urandom_range(N_IDS + 1, 255));
  endfunction

  // Tick moves forward mostly in small steps, repeats to make stamp ties,
  // and now and then jumps anywhere.
  function automatic logic [TICK_W-1:0] step_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      tick_now = tick_now;
    else if (r < 80) tick_now = tick_now + $urandom_range(1, 300);
    else if (r < 95) tick_now = tick_now + $urandom_range(301, 2000);
    else             tick_now = $urandom;
    return tick_now;
  endfunction

  task automatic new_pool();
    for (int i = 0; i < POOL_N; i++) mac_pool[i] = rand_mac();
    if ($urandom_range(0, 1)) mac_pool[0] = '0;
    if ($urandom_range(0, 1)) mac_pool[1] = '1;
    tick_now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 : $urandom;
  endtask

  // Mostly announce + id runs over a small address pool; the rest is
  // queries, stray ids, unused opcodes and one-off addresses.
  task automatic run_traffic(input int n_words);
    int               done;
    int               r;
    int               nid;
    logic [COUNT_W-1:0] cnt;
    done = 0;
    new_pool();
    while (done < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        cnt = pick_count();
        send_word(OP_ANNOUNCE, mac_pool[$urandom_range(0, POOL_N - 1)], step_tick(), cnt,
                  $urandom);
        done++;
        nid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, N_IDS + 2)
                                          : ((cnt > N_IDS) ? N_IDS : int'(cnt));
        for (int k = 0; k < nid; k++) begin
          send_word(OP_ID, rand_mac(), $urandom, COUNT_W'($urandom), $urandom);
          done++;
        end
      end else if (r < 80) begin
        send_word(OP_COUNT, rand_mac(), ($urandom_range(0, 9) == 0) ? $urandom : step_tick(),
                  COUNT_W'($urandom), $urandom);
        done++;
      end else if (r < 90) begin
        send_word(OP_ID, rand_mac(), $urandom, COUNT_W'($urandom), $urandom);
        done++;
      end else if (r < 95) begin
        send_word(OP_UNUSED, rand_mac(), $urandom, COUNT_W'($urandom), $urandom);
        done++;
      end else begin
        send_word(OP_ANNOUNCE, rand_mac(), step_tick(), COUNT_W'($urandom), $urandom);
        done++;
      end
    end
  endtask

  task automatic test_directed();
    logic [MAC_W-1:0] ones_mac;
    ones_mac = '1;
    // id before any announce, unused opcode, empty table query
    send_word(OP_ID, '0, '0, '0, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, '1, '1, '1, '1);
    send_word(OP_COUNT, '0, '0, '0, '0);
    // wildcard announce, then an id that must be dropped
    send_word(OP_ANNOUNCE, '0, '0, 8'd0, '0);
    send_word(OP_ID, '0, '0, '0, '0);
    // count above capacity: eight ids stored, the ninth dropped
    send_word(OP_ANNOUNCE, ones_mac, 32'hFFFF_FFFF, 8'd255, '0);
    send_word(OP_ID, '0, '0, '0, 32'h0000_0000);
    send_word(OP_ID, '0, '0, '0, 32'hFFFF_FFFF);
    for (int k = 0; k < N_IDS - 1; k++)
      send_word(OP_ID, '0, '0, '0, 32'hA5A5_0000 + k);
    // same address again: existing slot, count used up after two ids
    send_word(OP_ANNOUNCE, ones_mac, 32'd5, 8'd2, '0);
    send_word(OP_ID, '0, '0, '0, 32'h1234_5678);
    send_word(OP_ID, '0, '0, '0, 32'h8765_4321);
    send_word(OP_ID, '0, '0, '0, 32'h0BAD_F00D);
    send_word(OP_COUNT, '0, 32'd10, '0, '0);
    // fill the rest with equal stamps, then force two evictions
    for (int s = 2; s < N_SLOTS; s++)
      send_word(OP_ANNOUNCE, 48'h0200_0000_0000 + s, 32'd100, 8'd1, '0);
    send_word(OP_ANNOUNCE, 48'h0300_0000_0001, 32'd100, 8'd1, '0);
    send_word(OP_ANNOUNCE, 48'h0300_0000_0002, 32'd100, 8'd8, '0);
    // query from behind every stamp: the wrapped age is huge
    send_word(OP_COUNT, '0, 32'd3, '0, '0);
    send_word(OP_COUNT, '0, 32'd1099, '0, '0);
  endtask

  task automatic test_liveness_extremes();
    set_liveness(32'd1);
    run_traffic(150);
    set_liveness(32'hFFFF_FFFF);
    run_traffic(150);
    set_liveness(32'd0);  // nothing can be alive
    run_traffic(150);
  endtask

  task automatic test_random_traffic();
    set_liveness($urandom_range(2, 400));
    run_traffic(200);
    set_liveness($urandom);
    run_traffic(200);
    set_liveness(LIVENESS_RESET);
    run_traffic(200);
  endtask

  // sender holds off until every result has come, several times over
  task automatic test_drain_pause();
    for (int p = 0; p < 4; p++) begin
      run_traffic(25);
      wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < N_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_mac[i]   = '0;
      tbl_seen[i]  = '0;
      tbl_wild[i]  = 1'b0;
      tbl_total[i] = 0;
      for (int k = 0; k < N_IDS; k++) tbl_ids[i][k] = '0;
    end
    cur_slot   = 0;
    fill_pos   = 0;
    live_limit = LIVENESS_RESET;
    tick_now   = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_liveness_extremes();
    test_random_traffic();
    test_drain_pause();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) report("results still pending", pending_results.size(), 0);
    $display("Covered %0d announces (%0d evictions), %0d id words, %0d queries, %0d unused",
             n_announce, n_evict, n_idword, n_query, n_other);
    $display("Liveness written %0d times, extremes and default included", n_settings);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver: switches its mode among always ready, coin flip
  // and occasional long stalls
  always @(posedge clk) begin
    rx_cnt = rx_cnt + 1;
    if (rx_cnt % 100 == 0) rx_mode = $urandom_range(0, 2);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (rx_mode == 1) begin
      m_tready <= 1'($urandom_range(0, 1));
    end else if (rx_mode == 2 && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(3, 24);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_results.size() == 0) begin
          report("result word with nothing pending, word", int'(m_tdata), 0);
        end else begin
          want = pending_results.pop_front();
          if (got.slot !== want.slot)   report("slot", got.slot, want.slot);
          if (got.fresh !== want.fresh) report("new_entry", got.fresh, want.fresh);
          if (got.evict !== want.evict) report("evicted", got.evict, want.evict);
          if (got.trunc !== want.trunc) report("truncated", got.trunc, want.trunc);
          if (got.alive !== want.alive) report("alive_count", got.alive, want.alive);
          if (got.pad !== want.pad)     report("padding bits", got.pad, want.pad);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
hw/rtl/stl_pkg.sv
hw/rtl/stl_entry_mem.sv
hw/rtl/stl_id_mem.sv
hw/rtl/stl_scan.sv
hw/rtl/subscriber_table_lru_top.sv
sim/testbench.sv
